// ----- design/ble_pkg.sv -----
// Package for the bounded list engine: sizes, operation and status codes,
// controller state encoding and the statistics control bundle.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package ble_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int POS_W  = 7;
  localparam int STAT_W = 2;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  // Width that holds both a position and a count plus one, for clamping.
  localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_PUSH   = 3'd1,
    OP_REMOVE = 3'd2,
    OP_DROP   = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_QUERY  = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_RM_RD,
    ST_RM_WR,
    ST_DR_RD,
    ST_DR_WR,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic vld;
  } stats_ctl_t;

endpackage

// ----- design/ble_ram.sv -----
// Entry store of the bounded list engine: one write port, one read port,
// registered read data. Sizes come from ble_pkg.
`timescale 1ns / 1ps

module ble_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ble_pkg::ADDR_W-1:0] waddr,
  input  logic [ble_pkg::DATA_W-1:0] wdata,
  input  logic [ble_pkg::ADDR_W-1:0] raddr,
  output logic [ble_pkg::DATA_W-1:0] rdata
);

  logic [ble_pkg::DATA_W-1:0] mem [ble_pkg::DEPTH];
  logic [ble_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/ble_stats.sv -----
// Statistics unit: two signed compares fold each scanned entry into top,
// bottom, maximum and the greater-than count. Uses ble_pkg.
`timescale 1ns / 1ps

module ble_stats (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ble_pkg::stats_ctl_t               ctl,
  input  logic signed [ble_pkg::DATA_W-1:0] rdata,
  input  logic signed [ble_pkg::DATA_W-1:0] ref_val,
  output logic signed [ble_pkg::DATA_W-1:0] top_value,
  output logic signed [ble_pkg::DATA_W-1:0] bottom_value,
  output logic signed [ble_pkg::DATA_W-1:0] max_value,
  output logic        [ble_pkg::CNT_W-1:0]  greater_count
);

  logic signed [ble_pkg::DATA_W-1:0] top_r, top_nxt;
  logic signed [ble_pkg::DATA_W-1:0] bot_r, bot_nxt;
  logic signed [ble_pkg::DATA_W-1:0] max_r, max_nxt;
  logic        [ble_pkg::CNT_W-1:0]  gt_r, gt_nxt;
  logic                              seen_r, seen_nxt;

  always_comb begin
    top_nxt  = top_r;
    bot_nxt  = bot_r;
    max_nxt  = max_r;
    gt_nxt   = gt_r;
    seen_nxt = seen_r;
    if (ctl.clr) begin
      top_nxt  = '0;
      bot_nxt  = '0;
      max_nxt  = '0;
      gt_nxt   = '0;
      seen_nxt = 1'b0;
    end else if (ctl.vld) begin
      bot_nxt  = rdata;
      seen_nxt = 1'b1;
      // The first entry seeds both the top and the running maximum.
      if (!seen_r) begin
        top_nxt = rdata;
        max_nxt = rdata;
      end else if (rdata > max_r) begin
        max_nxt = rdata;
      end
      if (rdata > ref_val) begin
        gt_nxt = gt_r + ble_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      gt_r   <= '0;
    end else begin
      seen_r <= seen_nxt;
      gt_r   <= gt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    bot_r <= bot_nxt;
    max_r <= max_nxt;
  end

  assign top_value     = top_r;
  assign bottom_value  = bot_r;
  assign max_value     = max_r;
  assign greater_count = gt_r;

endmodule

// ----- design/ble_ctrl.sv -----
// Sequencer of the bounded list engine: walks the entry store to shift,
// compact or scan it, and keeps the entry count. Uses ble_pkg.
`timescale 1ns / 1ps

module ble_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [ble_pkg::OP_W-1:0]          operation,
  input  logic signed [ble_pkg::DATA_W-1:0] value,
  input  logic [ble_pkg::POS_W-1:0]         position,
  output logic                              busy,
  output logic                              done,
  output logic [ble_pkg::STAT_W-1:0]        status,
  output logic [ble_pkg::CNT_W-1:0]         entry_count,
  output logic signed [ble_pkg::DATA_W-1:0] ref_val,
  output logic                              mem_we,
  output logic [ble_pkg::ADDR_W-1:0]        mem_waddr,
  output logic [ble_pkg::DATA_W-1:0]        mem_wdata,
  output logic [ble_pkg::ADDR_W-1:0]        mem_raddr,
  input  logic [ble_pkg::DATA_W-1:0]        mem_rdata,
  output ble_pkg::stats_ctl_t               stats_ctl
);

  ble_pkg::state_t                    state_r, state_nxt;
  ble_pkg::status_t                   status_r, status_nxt;
  logic [ble_pkg::CNT_W-1:0]          occ_r, occ_nxt;
  logic [ble_pkg::CNT_W-1:0]          cur_r, cur_nxt;
  logic [ble_pkg::CNT_W-1:0]          wr_r, wr_nxt;
  logic [ble_pkg::ADDR_W-1:0]         tgt_r, tgt_nxt;
  logic signed [ble_pkg::DATA_W-1:0]  val_r, val_nxt;
  logic                               pend_r, pend_nxt;

  logic [ble_pkg::CNT_W-1:0]          cur_m1;
  logic [ble_pkg::CMP_W-1:0]          pos_one;
  logic [ble_pkg::CMP_W-1:0]          occ_p1;
  logic [ble_pkg::CMP_W-1:0]          pos_clamp;
  logic [ble_pkg::CMP_W-1:0]          pos_m1;

  assign cur_m1    = cur_r - ble_pkg::CNT_W'(1);
  // Position zero means the top; anything past the end appends.
  assign pos_one   = (position == '0) ? ble_pkg::CMP_W'(1) : ble_pkg::CMP_W'(position);
  assign occ_p1    = ble_pkg::CMP_W'(occ_r) + ble_pkg::CMP_W'(1);
  assign pos_clamp = (pos_one > occ_p1) ? occ_p1 : pos_one;
  assign pos_m1    = pos_clamp - ble_pkg::CMP_W'(1);

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    occ_nxt    = occ_r;
    cur_nxt    = cur_r;
    wr_nxt     = wr_r;
    tgt_nxt    = tgt_r;
    val_nxt    = val_r;
    pend_nxt   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = cur_r[ble_pkg::ADDR_W-1:0];
    mem_wdata  = mem_rdata;
    mem_raddr  = cur_r[ble_pkg::ADDR_W-1:0];
    stats_ctl  = '0;

    case (state_r)
      ble_pkg::ST_IDLE: begin
        if (start) begin
          stats_ctl.clr = 1'b1;
          val_nxt       = value;
          status_nxt    = ble_pkg::STAT_OK;
          cur_nxt       = '0;
          wr_nxt        = '0;
          state_nxt     = ble_pkg::ST_SCAN;
          case (operation)
            ble_pkg::OP_INSERT, ble_pkg::OP_PUSH: begin
              if (occ_r >= ble_pkg::CNT_W'(ble_pkg::DEPTH)) begin
                status_nxt = ble_pkg::STAT_FULL;
              end else begin
                tgt_nxt   = (operation == ble_pkg::OP_PUSH) ? '0
                                                            : pos_m1[ble_pkg::ADDR_W-1:0];
                cur_nxt   = occ_r;
                state_nxt = ble_pkg::ST_INS_RD;
              end
            end
            ble_pkg::OP_REMOVE: begin
              state_nxt = ble_pkg::ST_RM_RD;
            end
            ble_pkg::OP_DROP: begin
              if (occ_r == '0) begin
                status_nxt = ble_pkg::STAT_EMPTY;
              end else begin
                cur_nxt   = ble_pkg::CNT_W'(1);
                state_nxt = ble_pkg::ST_DR_RD;
              end
            end
            ble_pkg::OP_CLEAR: begin
              occ_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Shift entries one place down from the bottom to the insert point.
      ble_pkg::ST_INS_RD: begin
        if (cur_r > ble_pkg::CNT_W'(tgt_r)) begin
          mem_raddr = cur_m1[ble_pkg::ADDR_W-1:0];
          state_nxt = ble_pkg::ST_INS_WR;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = tgt_r;
          mem_wdata = val_r;
          occ_nxt   = occ_r + ble_pkg::CNT_W'(1);
          cur_nxt   = '0;
          state_nxt = ble_pkg::ST_SCAN;
        end
      end

      ble_pkg::ST_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r[ble_pkg::ADDR_W-1:0];
        cur_nxt   = cur_m1;
        state_nxt = ble_pkg::ST_INS_RD;
      end

      // Compact in place: the write pointer never passes the read pointer.
      ble_pkg::ST_RM_RD: begin
        if (cur_r < occ_r) begin
          state_nxt = ble_pkg::ST_RM_WR;
        end else begin
          occ_nxt   = wr_r;
          cur_nxt   = '0;
          state_nxt = ble_pkg::ST_SCAN;
        end
      end

      ble_pkg::ST_RM_WR: begin
        if (mem_rdata != val_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_r[ble_pkg::ADDR_W-1:0];
          wr_nxt    = wr_r + ble_pkg::CNT_W'(1);
        end
        cur_nxt   = cur_r + ble_pkg::CNT_W'(1);
        state_nxt = ble_pkg::ST_RM_RD;
      end

      ble_pkg::ST_DR_RD: begin
        if (cur_r < occ_r) begin
          state_nxt = ble_pkg::ST_DR_WR;
        end else begin
          occ_nxt   = occ_r - ble_pkg::CNT_W'(1);
          cur_nxt   = '0;
          state_nxt = ble_pkg::ST_SCAN;
        end
      end

      ble_pkg::ST_DR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_m1[ble_pkg::ADDR_W-1:0];
        cur_nxt   = cur_r + ble_pkg::CNT_W'(1);
        state_nxt = ble_pkg::ST_DR_RD;
      end

      // One read issued per cycle; the data arrives in the cycle after.
      ble_pkg::ST_SCAN: begin
        stats_ctl.vld = pend_r;
        if (cur_r < occ_r) begin
          cur_nxt  = cur_r + ble_pkg::CNT_W'(1);
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          state_nxt = ble_pkg::ST_DONE;
        end
      end

      ble_pkg::ST_DONE: begin
        state_nxt = ble_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = ble_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ble_pkg::ST_IDLE;
      occ_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    cur_r    <= cur_nxt;
    wr_r     <= wr_nxt;
    tgt_r    <= tgt_nxt;
    val_r    <= val_nxt;
  end

  assign busy        = (state_r != ble_pkg::ST_IDLE);
  assign done        = (state_r == ble_pkg::ST_DONE);
  assign status      = status_r;
  assign entry_count = occ_r;
  assign ref_val     = val_r;

endmodule

// ----- design/bounded_list_engine_core.sv -----
// Bounded list engine: ordered list of up to DEPTH signed words with insert,
// push, remove-all, drop, clear and query; one result per command.
// Each command first shifts, compacts or examines entries as needed, then scans the
// list to rebuild the statistics and finally raises the result strobe.
// Busy stays high until the strobe ends; the receiver cannot stall the strobe.
// Reset empties the list at once; store contents are not cleared.
`timescale 1ns / 1ps

module bounded_list_engine_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [ble_pkg::OP_W-1:0]          in_operation,
  input  logic signed [ble_pkg::DATA_W-1:0] in_value,
  input  logic [ble_pkg::POS_W-1:0]         in_position,
  output logic                              out_valid,
  output logic [ble_pkg::STAT_W-1:0]        out_status,
  output logic [ble_pkg::CNT_W-1:0]         out_entry_count,
  output logic signed [ble_pkg::DATA_W-1:0] out_top_value,
  output logic signed [ble_pkg::DATA_W-1:0] out_bottom_value,
  output logic signed [ble_pkg::DATA_W-1:0] out_max_value,
  output logic [ble_pkg::CNT_W-1:0]         out_greater_count
);

  logic                              mem_we;
  logic [ble_pkg::ADDR_W-1:0]        mem_waddr;
  logic [ble_pkg::DATA_W-1:0]        mem_wdata;
  logic [ble_pkg::ADDR_W-1:0]        mem_raddr;
  logic [ble_pkg::DATA_W-1:0]        mem_rdata;
  logic signed [ble_pkg::DATA_W-1:0] ref_val;
  ble_pkg::stats_ctl_t               stats_ctl;

  ble_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .operation   (in_operation),
    .value       (in_value),
    .position    (in_position),
    .busy        (busy),
    .done        (out_valid),
    .status      (out_status),
    .entry_count (out_entry_count),
    .ref_val     (ref_val),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .stats_ctl   (stats_ctl)
  );

  ble_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ble_stats u_stats (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (stats_ctl),
    .rdata         (mem_rdata),
    .ref_val       (ref_val),
    .top_value     (out_top_value),
    .bottom_value  (out_bottom_value),
    .max_value     (out_max_value),
    .greater_count (out_greater_count)
  );

  // A command is taken only when idle and keeps the engine busy after.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // Results are single-cycle strobes followed by a return to idle.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  // A rejected insert only happens on a full list.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ble_pkg::STAT_FULL
      |-> out_entry_count == ble_pkg::CNT_W'(ble_pkg::DEPTH))
    else $error("full status with list not full");

  // An empty list reports zero statistics.
  a_empty_stats: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_count == '0
      |-> out_greater_count == '0 && out_max_value == '0 && out_top_value == '0)
    else $error("empty list reported nonzero statistics");

  // The list never grows past its capacity and the greater-than count never exceeds the entry count.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= ble_pkg::CNT_W'(ble_pkg::DEPTH)
      && out_greater_count <= out_entry_count)
    else $error("count out of range");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for bounded_list_engine_core: directed and random
// command traffic, an in-bench list predictor and a result checker.
// Depends on ble_pkg for widths and the operation and status codes.
`timescale 1ns / 1ps

module testbench;

  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 3 * ble_pkg::DEPTH + 10;
  localparam logic signed [ble_pkg::DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [ble_pkg::DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;

  typedef struct packed {
    logic [ble_pkg::STAT_W-1:0] status;
    logic [ble_pkg::CNT_W-1:0]  count;
    logic [ble_pkg::DATA_W-1:0] top;
    logic [ble_pkg::DATA_W-1:0] bottom;
    logic [ble_pkg::DATA_W-1:0] maxv;
    logic [ble_pkg::CNT_W-1:0]  greater;
  } list_report_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [ble_pkg::OP_W-1:0] in_operation = '0;
  logic signed [ble_pkg::DATA_W-1:0] in_value = '0;
  logic [ble_pkg::POS_W-1:0] in_position = '0;
  logic out_valid;
  logic [ble_pkg::STAT_W-1:0] out_status;
  logic [ble_pkg::CNT_W-1:0] out_entry_count;
  logic signed [ble_pkg::DATA_W-1:0] out_top_value;
  logic signed [ble_pkg::DATA_W-1:0] out_bottom_value;
  logic signed [ble_pkg::DATA_W-1:0] out_max_value;
  logic [ble_pkg::CNT_W-1:0] out_greater_count;

  // Predicted list contents, position 1 at index 0.
  logic signed [ble_pkg::DATA_W-1:0] list_mem [ble_pkg::DEPTH];
  int list_count = 0;
  list_report_t expected_reports[$];

  bit gaps_on = 1'b1;
  int errors = 0;
  int items_sent = 0;
  int reports_checked = 0;
  int full_rejects = 0;
  int empty_drops = 0;
  int peak_count = 0;
  int quiet_cycles = 0;

  bounded_list_engine_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_top_value    (out_top_value),
    .out_bottom_value (out_bottom_value),
    .out_max_value    (out_max_value),
    .out_greater_count(out_greater_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one command to the predicted list and returns the report it should produce.
  function automatic list_report_t apply_list_op(logic [ble_pkg::OP_W-1:0] op,
                                                 logic signed [ble_pkg::DATA_W-1:0] v,
                                                 logic [ble_pkg::POS_W-1:0] p);
    list_report_t r;
    logic signed [ble_pkg::DATA_W-1:0] biggest;
    int slot;
    int w;
    int i;
    r = '0;
    r.status = ble_pkg::STAT_OK;
    case (op)
      ble_pkg::OP_INSERT, ble_pkg::OP_PUSH: begin
        if (list_count >= ble_pkg::DEPTH) begin
          r.status = ble_pkg::STAT_FULL;
          full_rejects++;
        end else begin
          slot = (op == ble_pkg::OP_PUSH) ? 1 : int'(p);
          if (slot < 1) slot = 1;
          if (slot > list_count + 1) slot = list_count + 1;
          for (i = list_count; i >= slot; i--) list_mem[i] = list_mem[i-1];
          list_mem[slot-1] = v;
          list_count++;
        end
      end
      ble_pkg::OP_REMOVE: begin
        w = 0;
        for (i = 0; i < list_count; i++) begin
          if (list_mem[i] != v) begin
            list_mem[w] = list_mem[i];
            w++;
          end
        end
        list_count = w;
      end
      ble_pkg::OP_DROP: begin
        if (list_count == 0) begin
          r.status = ble_pkg::STAT_EMPTY;
          empty_drops++;
        end else begin
          for (i = 1; i < list_count; i++) list_mem[i-1] = list_mem[i];
          list_count--;
        end
      end
      ble_pkg::OP_CLEAR: list_count = 0;
      default: ;
    endcase
    if (list_count > peak_count) peak_count = list_count;
    r.count = list_count[ble_pkg::CNT_W-1:0];
    if (list_count > 0) begin
      biggest = list_mem[0];
      for (i = 0; i < list_count; i++) begin
        if (list_mem[i] > biggest) biggest = list_mem[i];
        if (list_mem[i] > v) r.greater++;
      end
      r.top = list_mem[0];
      r.bottom = list_mem[list_count-1];
      r.maxv = biggest;
    end
    return r;
  endfunction

  // Sends one command; returns right after the edge at which it was accepted.
  task automatic send_cmd(logic [ble_pkg::OP_W-1:0] op,
                          logic signed [ble_pkg::DATA_W-1:0] v,
                          logic [ble_pkg::POS_W-1:0] p);
    int gap;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_value <= v;
    in_position <= p;
    do @(posedge clk); while (busy);
    expected_reports.push_back(apply_list_op(op, v, p));
    items_sent++;
  endtask

  function automatic logic signed [ble_pkg::DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3 && list_count > 0) return list_mem[$urandom_range(0, list_count - 1)];
    if (r < 6) return $urandom_range(0, 6) - 3;
    if (r < 9) return $urandom;
    case ($urandom_range(0, 3))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic logic [ble_pkg::POS_W-1:0] pick_position();
    if ($urandom_range(0, 3) == 0) return ble_pkg::POS_W'($urandom_range(0, 127));
    return ble_pkg::POS_W'($urandom_range(0, list_count + 2));
  endfunction

  task automatic test_empty_list_cases();
    send_cmd(ble_pkg::OP_QUERY, 0, 0);
    send_cmd(ble_pkg::OP_DROP, 0, 0);
    send_cmd(ble_pkg::OP_REMOVE, 5, 0);
    send_cmd(ble_pkg::OP_CLEAR, -1, 0);
    send_cmd(3'd6, 1, 0);
    send_cmd(3'd7, -1, 7'h7f);
  endtask

  task automatic test_insert_positions();
    send_cmd(ble_pkg::OP_INSERT, 10, 0);
    send_cmd(ble_pkg::OP_INSERT, MOST_NEG, 7'h7f);
    // Positions equal to the current count place the item just above the bottom.
    send_cmd(ble_pkg::OP_INSERT, MOST_POS, 2);
    send_cmd(ble_pkg::OP_INSERT, -1, 3);
    send_cmd(ble_pkg::OP_PUSH, 0, 7'h55);
    send_cmd(ble_pkg::OP_INSERT, 3, 6);
    send_cmd(ble_pkg::OP_QUERY, -1, 0);
    send_cmd(ble_pkg::OP_QUERY, MOST_NEG, 0);
    send_cmd(ble_pkg::OP_QUERY, MOST_POS, 0);
  endtask

  task automatic test_remove_cases();
    send_cmd(ble_pkg::OP_PUSH, 10, 0);
    send_cmd(ble_pkg::OP_PUSH, 10, 0);
    // Repeated matches at the head must all go in one pass.
    send_cmd(ble_pkg::OP_REMOVE, 10, 0);
    send_cmd(ble_pkg::OP_REMOVE, 42, 0);
    send_cmd(ble_pkg::OP_DROP, 0, 0);
    send_cmd(ble_pkg::OP_CLEAR, 0, 0);
    send_cmd(ble_pkg::OP_DROP, 0, 0);
  endtask

  task automatic test_capacity();
    send_cmd(ble_pkg::OP_CLEAR, 0, 0);
    while (list_count < ble_pkg::DEPTH) begin
      if ($urandom_range(0, 1) == 0) send_cmd(ble_pkg::OP_PUSH, pick_value(), pick_position());
      else send_cmd(ble_pkg::OP_INSERT, pick_value(), pick_position());
    end
    send_cmd(ble_pkg::OP_INSERT, MOST_POS, 0);
    send_cmd(ble_pkg::OP_PUSH, MOST_NEG, 0);
    send_cmd(ble_pkg::OP_INSERT, 1, 7'h7f);
    send_cmd(ble_pkg::OP_QUERY, pick_value(), 0);
    send_cmd(ble_pkg::OP_DROP, 0, 0);
    send_cmd(ble_pkg::OP_INSERT, MOST_POS, 7'h7f);
    send_cmd(ble_pkg::OP_REMOVE, pick_value(), 0);
  endtask

  // Random traffic in phases that each grow, shrink or churn the list, chosen at random.
  task automatic test_random_traffic(int total);
    int left;
    int phase_len;
    int bias;
    int r;
    logic [ble_pkg::OP_W-1:0] op;
    left = total;
    while (left > 0) begin
      phase_len = $urandom_range(60, 200);
      if (phase_len > left) phase_len = left;
      bias = $urandom_range(0, 2);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (bias == 0) begin
          op = (r < 40) ? ble_pkg::OP_INSERT : (r < 65) ? ble_pkg::OP_PUSH :
               (r < 75) ? ble_pkg::OP_REMOVE : (r < 85) ? ble_pkg::OP_DROP :
               (r < 86) ? ble_pkg::OP_CLEAR : (r < 96) ? ble_pkg::OP_QUERY :
               3'($urandom_range(6, 7));
        end else if (bias == 1) begin
          op = (r < 15) ? ble_pkg::OP_INSERT : (r < 25) ? ble_pkg::OP_PUSH :
               (r < 50) ? ble_pkg::OP_REMOVE : (r < 85) ? ble_pkg::OP_DROP :
               (r < 88) ? ble_pkg::OP_CLEAR : (r < 96) ? ble_pkg::OP_QUERY :
               3'($urandom_range(6, 7));
        end else begin
          op = 3'($urandom_range(0, 7));
        end
        send_cmd(op, pick_value(), pick_position());
      end
      left -= phase_len;
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin : check_reports
    list_report_t got;
    list_report_t want;
    if (rst_n && out_valid) begin
      got.status = out_status;
      got.count = out_entry_count;
      got.top = out_top_value;
      got.bottom = out_bottom_value;
      got.maxv = out_max_value;
      got.greater = out_greater_count;
      reports_checked++;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with no transaction pending: count %0d",
                                   got.count);
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch (expected/actual): status %0d/%0d count %0d/%0d",
                     want.status, got.status, want.count, got.count);
            $display("  top %0d/%0d bottom %0d/%0d max %0d/%0d greater %0d/%0d",
                     $signed(want.top), $signed(got.top),
                     $signed(want.bottom), $signed(got.bottom),
                     $signed(want.maxv), $signed(got.maxv),
                     want.greater, got.greater);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_reports.size());
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list_cases();
    test_insert_positions();
    test_remove_cases();
    test_capacity();
    test_random_traffic(1560);
    start <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d commands sent, %0d results checked, peak occupancy %0d",
             items_sent, reports_checked, peak_count);
    $display("%0d inserts rejected on a full list, %0d drops on an empty list",
             full_rejects, empty_drops);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
